@@ sv/i2cmbe_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared types, opcodes, sequencer phase codes and fixed hold lengths.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

    // Widths
    localparam int HALF_PERIOD_BITS = 16;
    localparam int PHASE_W          = 5;
    localparam int BYTE_BITS        = 8;
    localparam int BIT_CNT_W        = 4;
    localparam int POLL_W           = 8;
    localparam int OPCODE_W         = 3;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 16;
    localparam int S_TDATA_W        = 16;
    localparam int S_TUSER_W        = 4;
    localparam int M_TDATA_W        = 16;

    // Register reset values
    localparam logic [HALF_PERIOD_BITS-1:0] RESET_HALF_PERIOD = HALF_PERIOD_BITS'(5);
    localparam logic [POLL_W-1:0]           RESET_ACK_TIMEOUT = POLL_W'(250);

    // Fixed hold lengths in ticks
    localparam logic [HALF_PERIOD_BITS-1:0] HOLD_START = HALF_PERIOD_BITS'(4);
    localparam logic [HALF_PERIOD_BITS-1:0] HOLD_STOP  = HALF_PERIOD_BITS'(5);
    localparam logic [HALF_PERIOD_BITS-1:0] HOLD_NACK  = HALF_PERIOD_BITS'(5);
    localparam logic [HALF_PERIOD_BITS-1:0] HOLD_ONE   = HALF_PERIOD_BITS'(1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = CFG_IDX_W'(1);

    // Command opcodes
    localparam logic [OPCODE_W-1:0] OP_INIT    = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_START   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_STOP    = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_WRITE   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_READ    = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_WAITACK = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_ACK     = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_NACK    = 3'd7;

    // Sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE    = 5'd0;
    localparam logic [PHASE_W-1:0] PH_INIT_A  = 5'd1;
    localparam logic [PHASE_W-1:0] PH_START_A = 5'd2;
    localparam logic [PHASE_W-1:0] PH_START_B = 5'd3;
    localparam logic [PHASE_W-1:0] PH_STOP_A  = 5'd4;
    localparam logic [PHASE_W-1:0] PH_STOP_B  = 5'd5;
    localparam logic [PHASE_W-1:0] PH_STOP_C  = 5'd6;
    localparam logic [PHASE_W-1:0] PH_WA_A    = 5'd7;
    localparam logic [PHASE_W-1:0] PH_WA_B    = 5'd8;
    localparam logic [PHASE_W-1:0] PH_WA_POLL = 5'd9;
    localparam logic [PHASE_W-1:0] PH_ACK_A   = 5'd10;
    localparam logic [PHASE_W-1:0] PH_NACK_A  = 5'd11;
    localparam logic [PHASE_W-1:0] PH_NACK_B  = 5'd12;
    localparam logic [PHASE_W-1:0] PH_WR_LO   = 5'd13;
    localparam logic [PHASE_W-1:0] PH_WR_HI   = 5'd14;
    localparam logic [PHASE_W-1:0] PH_RD_LO   = 5'd15;
    localparam logic [PHASE_W-1:0] PH_RD_HI   = 5'd16;

    // One tick as it enters the sequencer
    typedef struct packed {
        logic                cmd_valid;
        logic [OPCODE_W-1:0] opcode;
        logic [7:0]          tx_byte;
        logic                sda_in;
    } tick_t;

    // Live configuration
    typedef struct packed {
        logic [HALF_PERIOD_BITS-1:0] half_period;
        logic [POLL_W-1:0]           ack_timeout;
    } cfg_t;

    // Result of one tick
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       ack;
    } res_t;

endpackage

@@ sv/i2c_master_bit_engine.sv @@
// ----------------------------------------------------------------------------
// I2C master bit engine
// Tick-driven I2C master: drives SCL and SDA through command sequences.
// ----------------------------------------------------------------------------
// Usage:
//   Each s_ beat is one timing tick carrying an optional command (tuser) and
//   the sampled SDA level (tdata). Every tick yields exactly one m_ beat with
//   the SCL/SDA drive levels, busy/done flags, last read byte and ack status.
//   A command offered while a sequence runs, including its completing tick,
//   is dropped.
//   A tick's result beat passes through the input register, then the result
//   register. The engine takes one tick per cycle while the result register
//   can take the beat (m_tready high or the result register empty).
//   The cfg channel is always ready; write it only while the engine is idle.
//   Reset: sequencer idle, SCL and SDA released high, half period 5 ticks,
//   ack timeout 250 polls, read byte and ack status cleared.
//   Stall: when m_tready is low the result beat holds, one further tick is
//   held in the input register, then s_tready drops until the result drains.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // tick input
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [i2cmbe_pkg::S_TDATA_W-1:0]     s_tdata,  // tx_byte[7:0], sda_in[8]
    input  logic [i2cmbe_pkg::S_TUSER_W-1:0]     s_tuser,  // cmd_valid[0], opcode[3:1]
    // result output
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [i2cmbe_pkg::M_TDATA_W-1:0]     m_tdata,  // scl_out[0], sda_out[1],
                                                            // busy_res[2], done_res[3],
                                                            // rx_byte[11:4],
                                                            // ack_received[12]
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [i2cmbe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [i2cmbe_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import i2cmbe_pkg::*;

    logic                        in_valid_reg;
    tick_t                       tick_reg;
    tick_t                       tick_in;
    logic                        out_valid_reg;
    res_t                        res_reg;
    res_t                        res_step;
    logic                        advance;
    cfg_t                        cfg;
    logic [HALF_PERIOD_BITS-1:0] half_period_reg;
    logic [POLL_W-1:0]           ack_timeout_reg;

    // Unpack the incoming beat
    always_comb begin
        tick_in.cmd_valid = s_tuser[0];
        tick_in.opcode    = s_tuser[OPCODE_W:1];
        tick_in.tx_byte   = s_tdata[BYTE_BITS-1:0];
        tick_in.sda_in    = s_tdata[BYTE_BITS];
    end

    // Step the sequencer when the result register can take the beat
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Configuration registers
    assign cfg_ready       = 1'b1;
    assign cfg.half_period = half_period_reg;
    assign cfg.ack_timeout = ack_timeout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= RESET_HALF_PERIOD;
            ack_timeout_reg <= RESET_ACK_TIMEOUT;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_HALF_PERIOD) begin
                half_period_reg <= cfg_data[HALF_PERIOD_BITS-1:0];
            end else if (cfg_index == CFG_ACK_TIMEOUT) begin
                ack_timeout_reg <= cfg_data[POLL_W-1:0];
            end
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            tick_reg <= tick_in;
        end
    end

    i2cmbe_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .tick    (tick_reg),
        .cfg     (cfg),
        .res     (res_step)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_step;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({res_reg.ack, res_reg.rx_byte, res_reg.done,
                                  res_reg.busy, res_reg.sda, res_reg.scl});

`ifndef SYNTHESIS
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with an empty result register");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && res_reg.done) |-> !res_reg.busy)
        else $error("completing tick reported busy");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result beat changed or dropped");
`endif

endmodule

@@ sv/i2cmbe_core.sv @@
// ----------------------------------------------------------------------------
// I2C master bit engine sequencer
// Holds the bus sequencer state and works out one tick per step.
// ----------------------------------------------------------------------------
module i2cmbe_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  i2cmbe_pkg::tick_t  tick,
    input  i2cmbe_pkg::cfg_t   cfg,
    output i2cmbe_pkg::res_t   res
);
    import i2cmbe_pkg::*;

    logic [PHASE_W-1:0]          phase_reg, phase_next;
    logic [BIT_CNT_W-1:0]        bit_count_reg, bit_count_next;
    logic [HALF_PERIOD_BITS-1:0] delay_reg, delay_next;
    logic [BYTE_BITS-1:0]        shift_reg, shift_next;
    logic [POLL_W-1:0]           poll_reg, poll_next;
    logic                        scl_reg, scl_next;
    logic                        sda_reg, sda_next;
    logic                        ack_reg, ack_next;
    logic [BYTE_BITS-1:0]        rx_reg, rx_next;
    logic                        done;
    logic [HALF_PERIOD_BITS-1:0] half_ticks;

    // Zero half period runs as one tick
    assign half_ticks = (cfg.half_period == '0) ? HOLD_ONE : cfg.half_period;

    // Work out the next state for one tick
    always_comb begin
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        delay_next     = delay_reg;
        shift_next     = shift_reg;
        poll_next      = poll_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        ack_next       = ack_reg;
        rx_next        = rx_reg;
        done           = 1'b0;
        if (phase_reg == PH_IDLE) begin
            if (tick.cmd_valid) begin
                unique case (tick.opcode)
                    OP_INIT: begin
                        scl_next   = 1'b1;
                        phase_next = PH_INIT_A;
                        delay_next = half_ticks;
                    end
                    OP_START: begin
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                        phase_next = PH_START_A;
                        delay_next = HOLD_START;
                    end
                    OP_STOP: begin
                        sda_next   = 1'b0;
                        scl_next   = 1'b0;
                        phase_next = PH_STOP_A;
                        delay_next = HOLD_STOP;
                    end
                    OP_WRITE: begin
                        shift_next     = tick.tx_byte;
                        bit_count_next = '0;
                        scl_next       = 1'b0;
                        sda_next       = tick.tx_byte[BYTE_BITS-1];
                        phase_next     = PH_WR_LO;
                        delay_next     = half_ticks;
                    end
                    OP_READ: begin
                        shift_next     = '0;
                        bit_count_next = '0;
                        sda_next       = 1'b1;
                        scl_next       = 1'b0;
                        phase_next     = PH_RD_LO;
                        delay_next     = half_ticks;
                    end
                    OP_WAITACK: begin
                        sda_next   = 1'b1;
                        poll_next  = '0;
                        phase_next = PH_WA_A;
                        delay_next = half_ticks;
                    end
                    OP_ACK: begin
                        sda_next   = 1'b0;
                        scl_next   = 1'b1;
                        phase_next = PH_ACK_A;
                        delay_next = HOLD_ONE;
                    end
                    OP_NACK: begin
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                        phase_next = PH_NACK_A;
                        delay_next = HOLD_NACK;
                    end
                endcase
            end
        end else if (phase_reg != PH_WA_POLL && delay_reg > HOLD_ONE) begin
            // Count down the current hold
            delay_next = delay_reg - HOLD_ONE;
        end else begin
            unique case (phase_reg)
                PH_INIT_A: begin
                    sda_next   = 1'b1;
                    phase_next = PH_IDLE;
                    delay_next = '0;
                    done       = 1'b1;
                end
                PH_START_A: begin
                    sda_next   = 1'b0;
                    phase_next = PH_START_B;
                    delay_next = half_ticks;
                end
                PH_START_B: begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    delay_next = '0;
                    done       = 1'b1;
                end
                PH_STOP_A: begin
                    scl_next   = 1'b1;
                    phase_next = PH_STOP_B;
                    delay_next = half_ticks;
                end
                PH_STOP_B: begin
                    sda_next   = 1'b1;
                    phase_next = PH_STOP_C;
                    delay_next = HOLD_STOP;
                end
                PH_STOP_C: begin
                    phase_next = PH_IDLE;
                    delay_next = '0;
                    done       = 1'b1;
                end
                PH_WA_A: begin
                    scl_next   = 1'b1;
                    phase_next = PH_WA_B;
                    delay_next = HOLD_ONE;
                end
                PH_WA_B: begin
                    phase_next = PH_WA_POLL;
                    delay_next = '0;
                end
                PH_WA_POLL: begin
                    // Low sample is an ACK; give up once the poll budget is spent
                    if (!tick.sda_in) begin
                        scl_next   = 1'b0;
                        ack_next   = 1'b1;
                        phase_next = PH_IDLE;
                        delay_next = '0;
                        done       = 1'b1;
                    end else if (poll_reg >= cfg.ack_timeout) begin
                        scl_next   = 1'b0;
                        ack_next   = 1'b0;
                        phase_next = PH_IDLE;
                        delay_next = '0;
                        done       = 1'b1;
                    end else begin
                        poll_next = poll_reg + POLL_W'(1);
                    end
                end
                PH_ACK_A: begin
                    scl_next   = 1'b0;
                    sda_next   = 1'b1;
                    phase_next = PH_IDLE;
                    delay_next = '0;
                    done       = 1'b1;
                end
                PH_NACK_A: begin
                    scl_next   = 1'b1;
                    phase_next = PH_NACK_B;
                    delay_next = half_ticks;
                end
                PH_NACK_B: begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    delay_next = '0;
                    done       = 1'b1;
                end
                PH_WR_LO: begin
                    scl_next   = 1'b1;
                    phase_next = PH_WR_HI;
                    delay_next = half_ticks;
                end
                PH_WR_HI: begin
                    // Shift out the next bit, MSB first
                    scl_next       = 1'b0;
                    shift_next     = {shift_reg[BYTE_BITS-2:0], 1'b0};
                    bit_count_next = bit_count_reg + BIT_CNT_W'(1);
                    if (bit_count_next < BIT_CNT_W'(BYTE_BITS)) begin
                        sda_next   = shift_next[BYTE_BITS-1];
                        phase_next = PH_WR_LO;
                        delay_next = half_ticks;
                    end else begin
                        phase_next = PH_IDLE;
                        delay_next = '0;
                        done       = 1'b1;
                    end
                end
                PH_RD_LO: begin
                    scl_next   = 1'b1;
                    phase_next = PH_RD_HI;
                    delay_next = half_ticks;
                end
                PH_RD_HI: begin
                    // Sample SDA at the end of the high half
                    scl_next       = 1'b0;
                    shift_next     = {shift_reg[BYTE_BITS-2:0], tick.sda_in};
                    bit_count_next = bit_count_reg + BIT_CNT_W'(1);
                    if (bit_count_next < BIT_CNT_W'(BYTE_BITS)) begin
                        phase_next = PH_RD_LO;
                        delay_next = half_ticks;
                    end else begin
                        rx_next    = shift_next;
                        phase_next = PH_IDLE;
                        delay_next = '0;
                        done       = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    delay_next = '0;
                end
            endcase
        end
    end

    // Result of this tick
    always_comb begin
        res.scl     = scl_next;
        res.sda     = sda_next;
        res.busy    = (phase_next != PH_IDLE);
        res.done    = done;
        res.rx_byte = rx_next;
        res.ack     = ack_next;
    end

    // Advance the state once per stepped tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            bit_count_reg <= '0;
            delay_reg     <= '0;
            shift_reg     <= '0;
            poll_reg      <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ack_reg       <= 1'b0;
            rx_reg        <= '0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            delay_reg     <= delay_next;
            shift_reg     <= shift_next;
            poll_reg      <= poll_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            ack_reg       <= ack_next;
            rx_reg        <= rx_next;
        end
    end

`ifndef SYNTHESIS
    a_bit_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_count_reg <= BIT_CNT_W'(BYTE_BITS))
        else $error("bit counter ran past one byte");

    a_idle_no_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (delay_reg == '0))
        else $error("hold counter left running in idle");

    a_hold_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_IDLE && phase_reg != PH_WA_POLL) |-> (delay_reg != '0))
        else $error("timed phase entered with an empty hold");

    a_poll_budget: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_WA_POLL) |-> (poll_reg <= cfg.ack_timeout))
        else $error("ack poll count beyond timeout");
`endif

endmodule
